### hw/rtl/rrca_pkg.sv
// ----------------------------------------------------------------------------
// rrca_pkg: shared types and codes of the reorder receiver
// Segment commands, result kinds, the store entry layout and the control and
// status groups passed between the controller and the cell chain.
// ----------------------------------------------------------------------------
package rrca_pkg;

	localparam int unsigned OffW = 32;
	localparam int unsigned LenW = 13;
	localparam int unsigned CmdW = 2;
	localparam int unsigned KindW = 2;

	// Longest payload accepted; longer lengths saturate to it
	localparam int unsigned MaxSegment = 5000;

	// Segment command codes
	localparam logic [CmdW-1:0] CmdData = 2'd0;
	localparam logic [CmdW-1:0] CmdFin  = 2'd1;

	// Result kind codes
	localparam logic [KindW-1:0] KindDeliver = 2'd0;
	localparam logic [KindW-1:0] KindAck     = 2'd1;
	localparam logic [KindW-1:0] KindFinack  = 2'd2;

	typedef enum logic [1:0] {
		StIdle,
		StEval,
		StDrain,
		StDone
	} state_t;

	// One early segment held in a cell
	typedef struct packed {
		logic            valid;
		logic [OffW-1:0] offset;
		logic [LenW-1:0] length;
	} entry_t;

	// Broadcast from the controller to every cell
	typedef struct packed {
		logic            drain;
		logic            insert;
		logic [OffW-1:0] expected;
		logic [OffW-1:0] ins_offset;
		logic [LenW-1:0] ins_length;
	} store_ctl_t;

	// Summary of the chain back to the controller
	typedef struct packed {
		logic            hit;
		logic            hit_match;
		logic [LenW-1:0] hit_length;
		logic            full;
	} store_stat_t;

endpackage

### hw/rtl/reorder_receiver_cumulative_ack.sv
// ----------------------------------------------------------------------------
// reorder_receiver_cumulative_ack: segment reassembly with cumulative ack
// Input channel: cmd, seq_offset, seg_length under in_valid / in_ready.
// Output channel: kind, out_offset, out_length, last under out_valid /
// out_ready; last marks the final result of one input transaction.
// A data segment at the expected offset is delivered, then stored segments
// that now fit are delivered, and a cumulative ack closes the sequence.
// Early segments go into a chain of QUEUE_DEPTH cells (dropped when full);
// late ones only cause the ack. A fin segment returns a finack, after which
// every input is accepted and dropped without a result.
// Flow: a descriptor is registered when taken and evaluated in the next
// cycle; an early, late or fin segment ends there, while an in-order one goes
// on to drain stored entries that fit or are stale, one chain removal per
// cycle unless a delivery waits for the output. Each result needs a free
// output register; a stalled receiver holds the sequence at the next result.
// Reset clears the expected offset, the cell valid flags and the fin state;
// there is no clearing pass and the block is ready in the first cycle.
// ----------------------------------------------------------------------------
module reorder_receiver_cumulative_ack #(
	parameter int unsigned QUEUE_DEPTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [rrca_pkg::CmdW-1:0]  cmd,
	input  logic [rrca_pkg::OffW-1:0]  seq_offset,
	input  logic [rrca_pkg::LenW-1:0]  seg_length,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [rrca_pkg::KindW-1:0] kind,
	output logic [rrca_pkg::OffW-1:0]  out_offset,
	output logic [rrca_pkg::LenW-1:0]  out_length,
	output logic                       last
);

	rrca_pkg::state_t state_q;
	rrca_pkg::state_t state_d;

	logic [rrca_pkg::CmdW-1:0]  cmd_q;
	logic [rrca_pkg::OffW-1:0]  off_q;
	logic [rrca_pkg::LenW-1:0]  len_q;
	logic [rrca_pkg::LenW-1:0]  len_sat;
	logic [rrca_pkg::OffW-1:0]  exp_q;
	logic [rrca_pkg::OffW-1:0]  exp_d;

	logic                       out_valid_q;
	logic [rrca_pkg::KindW-1:0] kind_q;
	logic [rrca_pkg::OffW-1:0]  offset_q;
	logic [rrca_pkg::LenW-1:0]  length_q;
	logic                       last_q;

	logic                       emit;
	logic [rrca_pkg::KindW-1:0] emit_kind;
	logic [rrca_pkg::OffW-1:0]  emit_offset;
	logic [rrca_pkg::LenW-1:0]  emit_length;
	logic                       emit_last;
	logic                       slot_free;
	logic                       in_acc;

	rrca_pkg::store_ctl_t  st_ctl;
	rrca_pkg::store_stat_t st_stat;

	assign in_ready  = (state_q == rrca_pkg::StIdle) || (state_q == rrca_pkg::StDone);
	assign in_acc    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	// Saturate overlong segments
	assign len_sat = (32'(seg_length) > 32'(rrca_pkg::MaxSegment))
		? rrca_pkg::LenW'(rrca_pkg::MaxSegment) : seg_length;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rrca_pkg::StIdle: begin
				if (in_acc) state_d = rrca_pkg::StEval;
			end
			rrca_pkg::StEval: begin
				if (cmd_q == rrca_pkg::CmdFin) begin
					if (slot_free) state_d = rrca_pkg::StDone;
				end else if (cmd_q == rrca_pkg::CmdData) begin
					if (slot_free) begin
						state_d = (off_q == exp_q) ? rrca_pkg::StDrain : rrca_pkg::StIdle;
					end
				end else begin
					state_d = rrca_pkg::StIdle;
				end
			end
			rrca_pkg::StDrain: begin
				if (!st_stat.hit && slot_free) state_d = rrca_pkg::StIdle;
			end
			rrca_pkg::StDone: begin
				state_d = rrca_pkg::StDone;
			end
			default: begin
				state_d = rrca_pkg::StIdle;
			end
		endcase
	end

	// Results, expected offset update and chain control
	always_comb begin
		emit           = 1'b0;
		emit_kind      = rrca_pkg::KindAck;
		emit_offset    = exp_q;
		emit_length    = '0;
		emit_last      = 1'b1;
		exp_d          = exp_q;
		st_ctl.drain      = 1'b0;
		st_ctl.insert     = 1'b0;
		st_ctl.expected   = exp_q;
		st_ctl.ins_offset = off_q;
		st_ctl.ins_length = len_q;
		case (state_q)
			rrca_pkg::StEval: begin
				if (cmd_q == rrca_pkg::CmdFin) begin
					emit      = slot_free;
					emit_kind = rrca_pkg::KindFinack;
				end else if (cmd_q == rrca_pkg::CmdData) begin
					emit = slot_free;
					if (off_q == exp_q) begin
						emit_kind   = rrca_pkg::KindDeliver;
						emit_offset = off_q;
						emit_length = len_q;
						emit_last   = 1'b0;
						if (slot_free) exp_d = exp_q + rrca_pkg::OffW'(len_q);
					end else if (off_q > exp_q) begin
						st_ctl.insert = slot_free && !st_stat.full;
					end
				end
			end
			rrca_pkg::StDrain: begin
				if (st_stat.hit && !st_stat.hit_match) begin
					// drop a stale entry, no result
					st_ctl.drain = 1'b1;
				end else if (st_stat.hit) begin
					st_ctl.drain = slot_free;
					emit         = slot_free;
					emit_kind    = rrca_pkg::KindDeliver;
					emit_length  = st_stat.hit_length;
					emit_last    = 1'b0;
					if (slot_free) exp_d = exp_q + rrca_pkg::OffW'(st_stat.hit_length);
				end else begin
					emit = slot_free;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rrca_pkg::StIdle;
			exp_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			exp_q   <= exp_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture the input transaction
	always_ff @(posedge clk) begin
		if (in_acc && (state_q == rrca_pkg::StIdle)) begin
			cmd_q <= cmd;
			off_q <= seq_offset;
			len_q <= len_sat;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q   <= emit_kind;
			offset_q <= emit_offset;
			length_q <= emit_length;
			last_q   <= emit_last;
		end
	end

	rrca_store #(
		.Depth (QUEUE_DEPTH)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (st_ctl),
		.stat   (st_stat)
	);

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign out_offset = offset_q;
	assign out_length = length_q;
	assign last       = last_q;

`ifndef ASSERT_OFF
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rrca_pkg::StDone |=> state_q == rrca_pkg::StDone)
		else $error("fin state left");

	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rrca_pkg::StDone && !out_valid_q) |=> !out_valid_q)
		else $error("result after fin");

	a_ack_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (kind_q == rrca_pkg::KindAck || kind_q == rrca_pkg::KindFinack))
		|-> last_q)
		else $error("ack without last");

	a_exp_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rrca_pkg::StIdle || state_q == rrca_pkg::StDone) |=> $stable(exp_q))
		else $error("expected offset moved while idle");

	a_drain_deliver: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rrca_pkg::StDrain && emit && emit_kind == rrca_pkg::KindDeliver)
		|=> (out_offset == $past(exp_q)))
		else $error("delivered offset differs from expected");
`endif

endmodule

### hw/rtl/rrca_cell.sv
// ----------------------------------------------------------------------------
// rrca_cell: one slot of the early-segment chain
// Holds one stored segment, compares it with the expected offset and takes
// its right neighbor's entry when it or an earlier cell is removed.
// ----------------------------------------------------------------------------
module rrca_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  rrca_pkg::store_ctl_t ctl,
	input  logic                prev_valid,
	input  logic                hit_in,
	input  rrca_pkg::entry_t    next_entry,
	output rrca_pkg::entry_t    entry,
	output logic                hit_out,
	output logic                sel,
	output logic                match
);

	logic                      valid_q;
	logic [rrca_pkg::OffW-1:0] offset_q;
	logic [rrca_pkg::LenW-1:0] length_q;
	logic                      stale;
	logic                      my_hit;
	logic                      take_next;
	logic                      take_ins;

	// Classify the held entry against the expected offset
	assign stale   = valid_q && (offset_q < ctl.expected);
	assign match   = valid_q && (offset_q == ctl.expected);
	assign my_hit  = stale || match;
	assign hit_out = hit_in || my_hit;
	assign sel     = my_hit && !hit_in;

	assign take_next = ctl.drain && hit_out;
	assign take_ins  = ctl.insert && !valid_q && prev_valid;

	assign entry = '{valid: valid_q, offset: offset_q, length: length_q};

	// Advance the valid flag: shift left on removal, set on insert
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take_next) begin
			valid_q <= next_entry.valid;
		end else if (take_ins) begin
			valid_q <= 1'b1;
		end
	end

	// Hold the segment payload
	always_ff @(posedge clk) begin
		if (take_next) begin
			offset_q <= next_entry.offset;
			length_q <= next_entry.length;
		end else if (take_ins) begin
			offset_q <= ctl.ins_offset;
			length_q <= ctl.ins_length;
		end
	end

endmodule

### hw/rtl/rrca_store.sv
// ----------------------------------------------------------------------------
// rrca_store: chain of cells holding early segments in arrival order
// Finds the earliest entry that is stale or matches the expected offset,
// removes it on a drain step and appends new entries at the first free cell.
// ----------------------------------------------------------------------------
module rrca_store #(
	parameter int unsigned Depth = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rrca_pkg::store_ctl_t  ctl,
	output rrca_pkg::store_stat_t stat
);

	rrca_pkg::entry_t entries [Depth+1];
	logic [Depth:0]   hit_chain;
	logic [Depth:0]   vld_chain;
	logic [Depth-1:0] sel_v;
	logic [Depth-1:0] match_v;

	assign hit_chain[0] = 1'b0;
	assign vld_chain[0] = 1'b1;
	assign entries[Depth] = '{valid: 1'b0, offset: '0, length: '0};

	// Build the row of cells
	for (genvar i = 0; i < Depth; i++) begin : g_cell
		assign vld_chain[i+1] = entries[i].valid;

		rrca_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.prev_valid (vld_chain[i]),
			.hit_in     (hit_chain[i]),
			.next_entry (entries[i+1]),
			.entry      (entries[i]),
			.hit_out    (hit_chain[i+1]),
			.sel        (sel_v[i]),
			.match      (match_v[i])
		);
	end

	// Pick the length of the selected cell (one-hot) and summarize the chain
	always_comb begin
		stat.hit_length = '0;
		stat.hit_match  = 1'b0;
		for (int i = 0; i < Depth; i++) begin
			if (sel_v[i]) begin
				stat.hit_length = stat.hit_length | entries[i].length;
				stat.hit_match  = stat.hit_match | match_v[i];
			end
		end
		stat.hit  = hit_chain[Depth];
		stat.full = entries[Depth-1].valid;
	end

endmodule

### tb/sv/reassembly_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reassembly_checker: result predictor and scoreboard for the reorder receiver
// Watches both channels. Each segment transaction is run through a local
// model of the reassembly state (next offset, early segment store, fin flag),
// and the results it causes are queued. Each result transaction is compared
// field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module reassembly_checker
	import rrca_pkg::*;
#(
	parameter int unsigned StoreDepth = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  logic [CmdW-1:0]  cmd,
	input  logic [OffW-1:0]  seq_offset,
	input  logic [LenW-1:0]  seg_length,
	input  logic             out_valid,
	input  logic             out_ready,
	input  logic [KindW-1:0] kind,
	input  logic [OffW-1:0]  out_offset,
	input  logic [LenW-1:0]  out_length,
	input  logic             last,
	output int               mismatches,
	output int               pending,
	output logic [OffW-1:0]  next_offset,
	output int               results_seen,
	output int               delivered,
	output int               stale_dropped,
	output int               full_dropped
);

	localparam int PrintLimit = 40;

	typedef struct packed {
		logic [KindW-1:0] kind;
		logic [OffW-1:0]  offset;
		logic [LenW-1:0]  length;
		logic             last;
	} seg_result_t;

	typedef struct packed {
		logic [OffW-1:0] offset;
		logic [LenW-1:0] length;
	} held_seg_t;

	seg_result_t     expected_results[$];
	held_seg_t       early_segs[$];
	logic [OffW-1:0] cur_offset = '0;
	logic            fin_seen = 1'b0;
	int              n_mismatch = 0;
	int              n_results = 0;
	int              n_delivered = 0;
	int              n_stale = 0;
	int              n_full = 0;
	int              n_pending = 0;

	assign mismatches    = n_mismatch;
	assign pending       = n_pending;
	assign next_offset   = cur_offset;
	assign results_seen  = n_results;
	assign delivered     = n_delivered;
	assign stale_dropped = n_stale;
	assign full_dropped  = n_full;

	// Print one line per mismatch (up to a limit) and count it
	task automatic report_mismatch(input string what, input logic [OffW-1:0] got,
			input logic [OffW-1:0] want);
		if (n_mismatch < PrintLimit) begin
			$display("%0t ns: mismatch on %s: got 'h%0h, want 'h%0h", $time, what, got, want);
		end
		n_mismatch++;
	endtask

	function automatic void push_result(input logic [KindW-1:0] k, input logic [OffW-1:0] off,
			input logic [LenW-1:0] len, input logic fin);
		seg_result_t r;
		r.kind   = k;
		r.offset = off;
		r.length = len;
		r.last   = fin;
		expected_results.push_back(r);
	endfunction

	// Work out the results of one segment transaction and advance the model
	function automatic void predict_segment(input logic [CmdW-1:0] c,
			input logic [OffW-1:0] off, input logic [LenW-1:0] raw_len);
		logic [LenW-1:0] seg_len;
		int best;
		int i;
		if (fin_seen) return;
		seg_len = (raw_len > MaxSegment) ? LenW'(MaxSegment) : raw_len;
		if (c == CmdFin) begin
			push_result(KindFinack, cur_offset, '0, 1'b1);
			fin_seen = 1'b1;
			return;
		end
		if (c != CmdData) return;

		if (off > cur_offset) begin
			// hold early segment, drop it when the store is full
			if (early_segs.size() < StoreDepth) early_segs.push_back('{off, seg_len});
			else n_full++;
		end else if (off == cur_offset) begin
			push_result(KindDeliver, off, seg_len, 1'b0);
			n_delivered++;
			cur_offset = cur_offset + seg_len;
			// drain: lowest offset first, earliest arrival wins a tie
			while (early_segs.size() > 0) begin
				best = 0;
				for (i = 1; i < early_segs.size(); i++) begin
					if (early_segs[i].offset < early_segs[best].offset) best = i;
				end
				if (early_segs[best].offset < cur_offset) begin
					early_segs.delete(best);
					n_stale++;
				end else if (early_segs[best].offset == cur_offset) begin
					push_result(KindDeliver, cur_offset, early_segs[best].length, 1'b0);
					n_delivered++;
					cur_offset = cur_offset + early_segs[best].length;
					early_segs.delete(best);
				end else begin
					break;
				end
			end
		end
		push_result(KindAck, cur_offset, '0, 1'b1);
	endfunction

	// Check result transactions, then predict from segment transactions
	always @(posedge clk or negedge arst_n) begin
		seg_result_t want;
		if (!arst_n) begin
			expected_results.delete();
			early_segs.delete();
			cur_offset = '0;
			fin_seen   = 1'b0;
			n_pending  = 0;
		end else begin
			if (out_valid && out_ready) begin
				n_results++;
				if (expected_results.size() == 0) begin
					report_mismatch("result with nothing expected, kind", OffW'(kind), '0);
				end else begin
					want = expected_results.pop_front();
					if (kind !== want.kind)
						report_mismatch("kind", OffW'(kind), OffW'(want.kind));
					if (out_offset !== want.offset)
						report_mismatch("out_offset", out_offset, want.offset);
					if (out_length !== want.length)
						report_mismatch("out_length", OffW'(out_length), OffW'(want.length));
					if (last !== want.last)
						report_mismatch("last", OffW'(last), OffW'(want.last));
				end
			end
			if (in_valid && in_ready) predict_segment(cmd, seq_offset, seg_length);
			n_pending = expected_results.size();
		end
	end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the reorder receiver
// Runs a directed opening (zero and overlong lengths, late segments, stale
// and equal-offset store entries, ignored commands), then windows of
// contiguous segments, most of them sent shuffled, with noise mixed in, including store
// overflow, under three idling profiles and one long output hold-off, and
// closes with fin. Checking is done by reassembly_checker.
// ----------------------------------------------------------------------------
module tb;
	import rrca_pkg::*;

	localparam int unsigned StoreDepth = 32;
	localparam int IdleLimit = 3000;
	localparam int HoldCycles = 400;
	localparam int DrainCycles = 40;
	localparam int WinMax = 48;
	localparam int FillWindow = 40;

	// Commands the block ignores
	localparam logic [CmdW-1:0] CmdOther = 2'd2;
	localparam logic [CmdW-1:0] CmdSpare = 2'd3;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic [CmdW-1:0]  cmd;
	logic [OffW-1:0]  seq_offset;
	logic [LenW-1:0]  seg_length;
	logic             out_valid;
	logic             out_ready;
	logic [KindW-1:0] kind;
	logic [OffW-1:0]  out_offset;
	logic [LenW-1:0]  out_length;
	logic             last;

	int              mismatches;
	int              pending;
	logic [OffW-1:0] next_offset;
	int              results_seen;
	int              delivered;
	int              stale_dropped;
	int              full_dropped;

	int send_idle;
	int recv_idle;
	bit hold_req;
	int segs_sent;

	always #5 clk = ~clk;

	reorder_receiver_cumulative_ack #(
		.QUEUE_DEPTH(StoreDepth)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.seq_offset(seq_offset),
		.seg_length(seg_length),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.out_offset(out_offset),
		.out_length(out_length),
		.last      (last)
	);

	reassembly_checker #(
		.StoreDepth(StoreDepth)
	) i_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.seq_offset   (seq_offset),
		.seg_length   (seg_length),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.out_offset   (out_offset),
		.out_length   (out_length),
		.last         (last),
		.mismatches   (mismatches),
		.pending      (pending),
		.next_offset  (next_offset),
		.results_seen (results_seen),
		.delivered    (delivered),
		.stale_dropped(stale_dropped),
		.full_dropped (full_dropped)
	);

	// Drive out_ready: random stalls, or a long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready = 1'b0;
				hold_left--;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HoldCycles - 1;
				out_ready = 1'b0;
			end else begin
				out_ready = ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// End the run when no transaction moves for too long
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < IdleLimit) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
			else idle_cycles++;
		end
		$display("Timeout: no transaction for %0d cycles, %0d results outstanding",
			IdleLimit, pending);
		$display("FAILED: results differ");
		$finish;
	end

	// Offer one segment after random idle cycles; hold it until accepted
	task automatic send_item(input logic [CmdW-1:0] c, input logic [OffW-1:0] off,
			input logic [LenW-1:0] len);
		while ($urandom_range(99) < send_idle) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid   = 1'b1;
		cmd        = c;
		seq_offset = off;
		seg_length = len;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		if (c == CmdData || c == CmdFin) segs_sent++;
	endtask

	// Stop offering until every expected result has come out
	task automatic wait_drained();
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// Noise: ignored command, late segment, or misaligned early segment
	task automatic send_noise(input logic [OffW-1:0] base, input logic [OffW-1:0] tail);
		case ($urandom_range(2))
			0: send_item($urandom_range(1) ? CmdOther : CmdSpare, $urandom(), LenW'($urandom()));
			1: send_item(CmdData, $urandom_range(base, 0), LenW'($urandom_range(1500)));
			default: send_item(CmdData, $urandom_range(tail, base), LenW'($urandom_range(1500)));
		endcase
	endtask

	// Send a run of contiguous segments from the current offset, usually shuffled;
	// with hold_first the in-order segment goes last so the store fills up
	task automatic send_window(input int nseg, input bit hold_first);
		logic [OffW-1:0] base;
		logic [OffW-1:0] pos;
		logic [OffW-1:0] offs[WinMax];
		logic [LenW-1:0] lens[WinMax];
		int order[WinMax];
		int i;
		int j;
		int tmp;
		int r;
		int span;
		base = next_offset;
		pos  = base;
		for (i = 0; i < nseg; i++) begin
			r = $urandom_range(99);
			if (r < 6) lens[i] = '0;
			else if (r < 12) lens[i] = LenW'(MaxSegment);
			else if (r < 17) lens[i] = LenW'($urandom_range(8191, MaxSegment + 1));
			else lens[i] = LenW'($urandom_range(1500, 1));
			offs[i] = pos;
			pos = pos + ((lens[i] > MaxSegment) ? OffW'(MaxSegment) : OffW'(lens[i]));
			order[i] = hold_first ? (i + 1) % nseg : i;
		end
		// shuffle, keeping the held segment at the end
		span = hold_first ? nseg - 1 : nseg;
		if (hold_first || $urandom_range(9) >= 3) begin
			for (i = span - 1; i > 0; i--) begin
				j = $urandom_range(i, 0);
				tmp = order[i];
				order[i] = order[j];
				order[j] = tmp;
			end
		end
		for (i = 0; i < nseg; i++) begin
			if ($urandom_range(99) < 10) send_noise(base, pos);
			send_item(CmdData, offs[order[i]], lens[order[i]]);
		end
	endtask

	// Opening cases: extremes, ignored commands, stale and tied store entries
	task automatic run_directed();
		send_item(CmdData, 32'd0, 13'd0);
		send_item(CmdData, 32'd0, 13'd100);
		send_item(CmdData, 32'd50, 13'd10);
		send_item(CmdData, 32'hFFFF_FFFF, 13'h1FFF);
		send_item(CmdOther, 32'd100, 13'd10);
		send_item(CmdSpare, 32'hFFFF_FFFF, 13'h1FFF);
		send_item(CmdData, 32'd300, LenW'(MaxSegment));
		send_item(CmdData, 32'd200, 13'd0);
		send_item(CmdData, 32'd200, 13'd100);
		send_item(CmdData, 32'd150, 13'd20);
		// release the chain: stale 150, ties at 200, then 300
		send_item(CmdData, 32'd100, 13'd100);
		send_item(CmdData, 32'd5300, 13'h1FFF);
		send_item(CmdData, 32'd0, 13'd1);
		send_item(CmdData, 32'd10300, LenW'(MaxSegment + 1));
	endtask

	// One idling profile: a store-filling window first, then random windows
	task automatic run_phase(input int s_idle, input int r_idle, input int target,
			input bit with_hold);
		int start;
		send_idle = s_idle;
		recv_idle = r_idle;
		start = segs_sent;
		if (with_hold) hold_req = 1'b1;
		send_window(FillWindow, 1'b1);
		while (segs_sent - start < target) begin
			send_window($urandom_range(10, 1), $urandom_range(3) == 0);
		end
		wait_drained();
	endtask

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		cmd        = CmdData;
		seq_offset = '0;
		seg_length = '0;
		send_idle  = 0;
		recv_idle  = 0;
		hold_req   = 1'b0;
		segs_sent  = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		run_directed();
		wait_drained();
		run_phase(16, 87, 110, 1'b1);
		run_phase(87, 16, 110, 1'b0);
		run_phase(0, 0, 110, 1'b0);

		// fin, then inputs that must be swallowed
		send_item(CmdFin, $urandom(), LenW'($urandom()));
		send_item(CmdData, next_offset, 13'd10);
		send_item(CmdFin, 32'd0, 13'd0);
		send_item(CmdOther, 32'd0, 13'd0);
		wait_drained();
		repeat (DrainCycles) @(negedge clk);

		$display("Run: %0d segments sent, %0d results checked, %0d deliveries",
			segs_sent, results_seen, delivered);
		$display("Store: %0d stale entries discarded, %0d early segments dropped when full",
			stale_dropped, full_dropped);
		if (mismatches == 0 && pending == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
